// ===== rtl/core/sfh_pkg.sv =====
// Shared types and constants for the spring force pipeline.
// No dependencies.
package sfh_pkg;

  localparam int unsigned DIFF_W = 33;
  localparam int unsigned SQ_W   = 66;
  localparam int unsigned LEN_W  = 33;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned REG_W  = 31;
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_STIFFNESS = 2'd0;
  localparam logic [IDX_W-1:0] REG_REST      = 2'd1;
  localparam logic [IDX_W-1:0] REG_BUNGEE    = 2'd2;

  // Per-axis magnitude and sign carried down the pipeline.
  typedef struct packed {
    logic [DIFF_W-1:0] mag;
    logic              pos;
  } axis_t;

  // Flags that travel with an item.
  typedef struct packed {
    logic slack;
    logic zero;
  } flags_t;

endpackage

// ===== rtl/core/sfh_sqrt.sv =====
// Pipelined restoring square root, one result bit per stage.
// Depends on sfh_pkg. Carries a side payload alongside each operand.
module sfh_sqrt #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [sfh_pkg::SQ_W-1:0]         radicand,
  input  logic [SIDE_W-1:0]                in_side,
  output logic                             out_valid,
  output logic [sfh_pkg::LEN_W-1:0]        root,
  output logic [SIDE_W-1:0]                out_side
);
  localparam int unsigned N = sfh_pkg::LEN_W;
  localparam int unsigned RW = sfh_pkg::LEN_W + 2;

  logic [N:0]                   vld;
  logic [sfh_pkg::SQ_W-1:0]     rad  [N+1];
  logic [RW-1:0]                rem  [N+1];
  logic [N-1:0]                 qt   [N+1];
  logic [SIDE_W-1:0]            side [N+1];

  assign vld[0]  = in_valid;
  assign rad[0]  = radicand;
  assign rem[0]  = '0;
  assign qt[0]   = '0;
  assign side[0] = in_side;

  // Each stage brings down two radicand bits and decides one root bit.
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [RW-1:0] trial;
    logic [RW-1:0] shifted;
    logic          take;
    always_comb begin
      shifted = {rem[s][RW-3:0], rad[s][sfh_pkg::SQ_W-1 -: 2]};
      trial   = {qt[s], 2'b01};
      take    = shifted >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad[s+1]  <= {rad[s][sfh_pkg::SQ_W-3:0], 2'b00};
        rem[s+1]  <= take ? shifted - trial : shifted;
        qt[s+1]   <= {qt[s][N-2:0], take};
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = qt[N];
  assign out_side  = side[N];
endmodule

// ===== rtl/core/sfh_div.sv =====
// Pipelined restoring divider: quotient of (num << FRAC) / den, QW bits.
// Depends on sfh_pkg for widths. Used for the unit vector components.
module sfh_div #(
  parameter int unsigned QW     = 17,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [sfh_pkg::DIFF_W-1:0]    num,
  input  logic [sfh_pkg::LEN_W-1:0]     den,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [QW-1:0]                 quo,
  output logic [SIDE_W-1:0]             out_side
);
  localparam int unsigned DW = sfh_pkg::LEN_W;

  logic [QW:0]       vld;
  logic [DW:0]       rem  [QW+1];
  logic [DW-1:0]     dv   [QW+1];
  logic [QW-1:0]     q    [QW+1];
  logic [SIDE_W-1:0] side [QW+1];

  // num <= den, so the integer part is one bit; the first stage compares num itself, unshifted, to decide it.
  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign dv[0]   = den;
  assign q[0]    = '0;
  assign side[0] = in_side;

  logic [DW:0] num_ext;
  assign num_ext = {1'b0, num};

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW+1:0] sh;
    logic          take;
    always_comb begin
      if (s == 0) begin
        sh = {1'b0, num_ext};
      end else begin
        sh = {rem[s], 1'b0};
      end
      take = sh >= {2'b00, dv[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= take ? (DW+1)'(sh - {2'b00, dv[s]}) : (DW+1)'(sh);
        dv[s+1]   <= dv[s];
        q[s+1]    <= {q[s][QW-2:0], take};
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign out_side  = side[QW];
endmodule

// ===== rtl/core/spring_force_hooke_core.sv =====
// Top level of the spring force pipeline: difference, root, divide, scale.
// One request per cycle; stalls freeze all.
// Throughput is one spring per cycle while not stalled; every stage is a register of its own.
// Reset is synchronous: valid bits clear, registers return to k = 1.0,
// rest length 1.0, bungee off. Depends on sfh_pkg, sfh_sqrt, sfh_div.
module spring_force_hooke_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sfh_pkg::IDX_W-1:0]    cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [31:0]           body_x,
  input  logic signed [31:0]           body_y,
  input  logic signed [31:0]           body_z,
  input  logic signed [31:0]           end_x,
  input  logic signed [31:0]           end_y,
  input  logic signed [31:0]           end_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           force_x,
  output logic signed [31:0]           force_y,
  output logic signed [31:0]           force_z,
  output logic                         applied
);
  localparam int unsigned DW = sfh_pkg::DIFF_W;
  localparam int unsigned LW = sfh_pkg::LEN_W;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned AXW = 3 * (DW + 1);

  logic [sfh_pkg::REG_W-1:0] stiffness;
  logic [sfh_pkg::REG_W-1:0] rest_len;
  logic                      bungee;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= sfh_pkg::REG_W'(65536);
      rest_len  <= sfh_pkg::REG_W'(65536);
      bungee    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfh_pkg::REG_STIFFNESS: stiffness <= cfg_data[30:0];
        sfh_pkg::REG_REST:      rest_len  <= cfg_data[30:0];
        sfh_pkg::REG_BUNGEE:    bungee    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances when the output slot is free or being taken.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: differences and magnitudes.
  logic           s1_v;
  sfh_pkg::axis_t s1_ax [3];
  logic signed [DW-1:0] dxyz [3];
  assign dxyz[0] = DW'(body_x) - DW'(end_x);
  assign dxyz[1] = DW'(body_y) - DW'(end_y);
  assign dxyz[2] = DW'(body_z) - DW'(end_z);

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_valid;
  end
  for (genvar i = 0; i < 3; i++) begin : g_s1
    always_ff @(posedge clk) begin
      if (en) begin
        s1_ax[i].mag <= dxyz[i][DW-1] ? DW'(-dxyz[i]) : DW'(dxyz[i]);
        s1_ax[i].pos <= !dxyz[i][DW-1] && (dxyz[i] != '0);
      end
    end
  end

  // Stage 2: squares (33x33 each) and their sum.
  logic               s2_v;
  logic [2*DW-1:0]    sq [3];
  sfh_pkg::axis_t     s2_ax [3];
  logic               s3_v;
  logic [sfh_pkg::SQ_W-1:0] s3_sum;
  sfh_pkg::axis_t     s3_ax [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end
  for (genvar i = 0; i < 3; i++) begin : g_s2
    always_ff @(posedge clk) begin
      if (en) begin
        sq[i]    <= s1_ax[i].mag * s1_ax[i].mag;
        s2_ax[i] <= s1_ax[i];
        s3_ax[i] <= s2_ax[i];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum <= sfh_pkg::SQ_W'(sq[0]) + sfh_pkg::SQ_W'(sq[1]) + sfh_pkg::SQ_W'(sq[2]);
    end
  end

  // Square root.
  logic          r_v;
  logic [LW-1:0] r_len;
  logic [AXW-1:0] r_side;
  sfh_sqrt #(.SIDE_W(AXW)) u_sqrt (
    .clk, .rst, .en,
    .in_valid (s3_v),
    .radicand (s3_sum),
    .in_side  ({s3_ax[0], s3_ax[1], s3_ax[2]}),
    .out_valid(r_v),
    .root     (r_len),
    .out_side (r_side)
  );
  sfh_pkg::axis_t r_ax [3];
  assign {r_ax[0], r_ax[1], r_ax[2]} = r_side;

  // Stage A: slack, zero, stretch magnitude; then the three dividers.
  logic          a_v;
  sfh_pkg::flags_t a_fl;
  logic [LW-1:0] a_len;
  logic [LW-1:0] a_str;
  sfh_pkg::axis_t a_ax [3];
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= r_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_fl.slack <= bungee && (r_len <= LW'(rest_len));
      a_fl.zero  <= r_len == '0;
      a_len      <= (r_len == '0) ? LW'(1) : r_len;
      a_str      <= (r_len >= LW'(rest_len)) ? r_len - LW'(rest_len)
                                             : LW'(rest_len) - r_len;
      a_ax       <= r_ax;
    end
  end

  localparam int unsigned SW = LW + 2 + 2 + 2;
  logic [QW-1:0] uq [3];
  logic [SW-1:0] d_side [3];
  logic [2:0]    d_v;
  for (genvar i = 0; i < 3; i++) begin : g_div
    sfh_div #(.QW(QW), .SIDE_W(SW)) u_div (
      .clk, .rst, .en,
      .in_valid (a_v),
      .num      (a_ax[i].mag),
      .den      (a_len),
      .in_side  ({a_str, a_fl, a_ax[0].pos, a_ax[1].pos, a_ax[2].pos, 1'b0}),
      .out_valid(d_v[i]),
      .quo      (uq[i]),
      .out_side (d_side[i])
    );
  end
  logic [LW-1:0]   b_str;
  sfh_pkg::flags_t b_fl;
  logic [2:0]      b_pos;
  logic            b_pad;
  assign {b_str, b_fl, b_pos, b_pad} = d_side[0];

  // Stage M: m = (stretch * k) >> FRAC (register after the multiply).
  localparam int unsigned MW = LW + sfh_pkg::REG_W;
  logic            m_v;
  logic [MW-1:0]   m_prod;
  logic [QW-1:0]   m_u [3];
  sfh_pkg::flags_t m_fl;
  logic [2:0]      m_pos;
  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (en) m_v <= d_v[0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_prod <= MW'(b_str) * MW'(stiffness);
      m_u    <= uq;
      m_fl   <= b_fl;
      m_pos  <= b_pos | {2'b00, b_pad};
    end
  end

  // Stage F: |F| = (m * u) >> FRAC, per axis.
  localparam int unsigned M2 = MW - FRAC_BITS;
  localparam int unsigned FW = M2 + QW;
  logic            f_v;
  logic [FW-1:0]   f_mag [3];
  sfh_pkg::flags_t f_fl;
  logic [2:0]      f_pos;
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (en) f_v <= m_v;
  end
  for (genvar i = 0; i < 3; i++) begin : g_f
    always_ff @(posedge clk) begin
      if (en) begin
        f_mag[i] <= FW'(m_prod[MW-1:FRAC_BITS]) * FW'(m_u[i]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_fl  <= m_fl;
      f_pos <= m_pos;
    end
  end

  // Output stage: shift, saturate, sign, special cases.
  logic signed [31:0] fo [3];
  for (genvar i = 0; i < 3; i++) begin : g_o
    logic [FW-FRAC_BITS-1:0] sh;
    always_comb begin
      sh = f_mag[i][FW-1:FRAC_BITS];
      if (f_fl.slack || f_fl.zero) begin
        fo[i] = '0;
      end else if (f_pos[2-i]) begin
        fo[i] = (sh > (FW-FRAC_BITS)'(33'h080000000)) ? 32'sh80000000
              : 32'(-sh);
      end else begin
        fo[i] = (sh > (FW-FRAC_BITS)'(33'h07fffffff)) ? 32'sh7fffffff
              : 32'(sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      force_x <= fo[0];
      force_y <= fo[1];
      force_z <= fo[2];
      applied <= !f_fl.slack;
    end
  end
endmodule

// ===== rtl/core/sfh_checker.sv =====
// Port-level checks for the spring force core, bound to the top level.
// Depends on spring_force_hooke_core ports only.
module sfh_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [31:0] force_x,
  input logic signed [31:0] force_y,
  input logic signed [31:0] force_z,
  input logic applied
);
  // A stalled result stays valid and holds its force_x and applied values.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(force_x) && $stable(applied))
    else $error("result changed under stall");

  // A slack result carries no force.
  a_slack: assert property (@(posedge clk) disable iff (rst)
    out_valid && !applied |-> force_x == 0 && force_y == 0 && force_z == 0)
    else $error("slack result with force");

  // The input side stalls only while the output side does.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // Nothing appears right after reset.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind spring_force_hooke_core sfh_checker u_sfh_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .force_x, .force_y, .force_z, .applied
);
